// File: rtl/vlns_pkg.sv
package vlns_pkg;

  localparam int DIM_W      = 7;
  localparam int ELEM_W     = 16;
  localparam int POS_W      = 6;
  localparam int VID_W      = 16;
  localparam int SUM_W      = 37;
  localparam int QUOT_W     = 33;
  localparam int ROOT_W     = 17;
  localparam int SREM_W     = 20;
  localparam int STEP_W     = 6;
  localparam int MAX_DIM_DEF  = 64;
  localparam int CAPACITY_DEF = 65536;
  localparam int DIM_RESET  = 64;

  localparam logic [0:0] REG_DIMENSION = 1'b0;
  localparam logic [0:0] REG_NORMALIZE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic             mode;
    logic [VID_W-1:0] vid;
    logic             bank;
  } desc_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DATA,
    B_DIV,
    B_SQRT,
    B_EMIT
  } back_state_t;

endpackage

// File: rtl/vlns_ram.sv
module vlns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/vlns_queue.sv
module vlns_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vlns_pkg::desc_t push_desc,
  input  logic            pop,
  output vlns_pkg::desc_t head,
  output logic            full,
  output logic            empty
);

  vlns_pkg::desc_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head  = slot_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/vlns_front.sv
module vlns_front #(
  parameter int MAX_DIM  = vlns_pkg::MAX_DIM_DEF,
  parameter int CAPACITY = vlns_pkg::CAPACITY_DEF,
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [vlns_pkg::DIM_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic [vlns_pkg::ELEM_W-1:0] in_element,
  output logic                        in_stall,
  input  logic                        q_full,
  output logic                        push,
  output vlns_pkg::desc_t             push_desc,
  output logic                        ram_we,
  output logic [IDX_W:0]              ram_waddr,
  output logic [vlns_pkg::ELEM_W-1:0] ram_wdata
);

  localparam int ID_W = $clog2(CAPACITY);

  logic [vlns_pkg::DIM_W-1:0] dim_r;
  logic                       mode_r;
  logic [vlns_pkg::DIM_W-1:0] cnt_r, cnt_nxt;
  logic [vlns_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [ID_W-1:0]            id_r, id_nxt;
  logic                       bank_r, bank_nxt;

  logic                       accept;
  logic [vlns_pkg::DIM_W-1:0] slot, n, eff_dim;
  logic signed [31:0]         sq;
  logic [vlns_pkg::SUM_W-1:0] sum_add;
  logic [31:0]                id_wide;
  logic                       done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (dim_r == '0) begin
      eff_dim = vlns_pkg::DIM_W'(1);
    end else if (32'(dim_r) > MAX_DIM) begin
      eff_dim = vlns_pkg::DIM_W'(MAX_DIM);
    end else begin
      eff_dim = dim_r;
    end
    slot = (32'(cnt_r) >= MAX_DIM) ? vlns_pkg::DIM_W'(MAX_DIM - 1) : cnt_r;
    n    = slot + 1'b1;
    sq   = $signed(in_element) * $signed(in_element);
    sum_add = sum_r + vlns_pkg::SUM_W'(unsigned'(sq));
    done = (n >= eff_dim);
  end

  assign ram_we    = accept;
  assign ram_waddr = {bank_r, slot[IDX_W-1:0]};
  assign ram_wdata = in_element;
  assign push      = accept && done;
  assign id_wide   = 32'(id_r);

  always_comb begin
    push_desc.count = n;
    push_desc.sum   = sum_add;
    push_desc.mode  = mode_r;
    push_desc.vid   = id_wide[vlns_pkg::VID_W-1:0];
    push_desc.bank  = bank_r;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    id_nxt   = id_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (done) begin
        cnt_nxt  = '0;
        sum_nxt  = '0;
        bank_nxt = ~bank_r;
        id_nxt   = (32'(id_r) == CAPACITY - 1) ? '0 : id_r + 1'b1;
      end else begin
        cnt_nxt = n;
        sum_nxt = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= vlns_pkg::DIM_W'(vlns_pkg::DIM_RESET);
      mode_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
      id_r   <= '0;
      bank_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vlns_pkg::REG_DIMENSION: dim_r  <= cfg_data;
          vlns_pkg::REG_NORMALIZE: mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      id_r   <= id_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// File: rtl/vlns_back.sv
module vlns_back #(
  parameter int MAX_DIM = vlns_pkg::MAX_DIM_DEF,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vlns_pkg::desc_t             head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        ram_re,
  output logic [IDX_W:0]              ram_raddr,
  input  logic [vlns_pkg::ELEM_W-1:0] ram_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vlns_pkg::ELEM_W-1:0] out_value,
  output logic [vlns_pkg::POS_W-1:0]  out_position,
  output logic [vlns_pkg::VID_W-1:0]  out_vector_id,
  output logic                        out_last
);

  vlns_pkg::back_state_t state_r, state_nxt;

  logic [vlns_pkg::DIM_W-1:0]  idx_r;
  logic                        neg_r;
  logic [vlns_pkg::ELEM_W-1:0] res_r;
  logic [vlns_pkg::SUM_W-1:0]  rem_r;
  logic [vlns_pkg::QUOT_W-1:0] num_r, quot_r;
  logic [vlns_pkg::QUOT_W:0]   rad_r;
  logic [vlns_pkg::SREM_W-1:0] srem_r;
  logic [vlns_pkg::ROOT_W-1:0] root_r;
  logic [vlns_pkg::STEP_W-1:0] step_r;
  logic                        out_valid_r;

  logic                        slot_free, is_last, direct, emit;
  logic [vlns_pkg::ELEM_W-1:0] x, mag;
  logic [31:0]                 mag2;
  logic [vlns_pkg::SUM_W:0]    div_sh, div_diff;
  logic [vlns_pkg::SREM_W-1:0] sq_sh, sq_trial;
  logic [vlns_pkg::ROOT_W:0]   q_half;
  logic [vlns_pkg::ROOT_W-1:0] q;
  logic [vlns_pkg::ELEM_W-1:0] res_norm;

  assign x       = ram_rdata;
  assign mag     = x[vlns_pkg::ELEM_W-1] ? -x : x;
  assign mag2    = 32'(mag) * 32'(mag);
  assign direct  = !head.mode || (x == '0) || (head.sum == '0);
  assign is_last = (idx_r + 1'b1 == head.count);
  assign slot_free = !out_valid_r || !out_stall;

  // long division step
  assign div_sh   = {rem_r, num_r[vlns_pkg::QUOT_W-1]};
  assign div_diff = div_sh - {1'b0, head.sum};

  // square root step, two radicand bits a step
  assign sq_sh    = {srem_r[vlns_pkg::SREM_W-3:0], rad_r[vlns_pkg::QUOT_W:vlns_pkg::QUOT_W-1]};
  assign sq_trial = vlns_pkg::SREM_W'({root_r, 2'b01});

  // round half up on the root, capped at one
  always_comb begin
    q_half = ({1'b0, root_r} + 1'b1) >> 1;
    q      = (q_half > 18'd32768) ? 17'd32768 : q_half[vlns_pkg::ROOT_W-1:0];
    if (!neg_r) begin
      res_norm = (q > 17'd32767) ? 16'd32767 : q[vlns_pkg::ELEM_W-1:0];
    end else begin
      res_norm = 16'(17'h10000 - q);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vlns_pkg::B_IDLE: if (!empty) state_nxt = vlns_pkg::B_READ;
      vlns_pkg::B_READ: state_nxt = vlns_pkg::B_DATA;
      vlns_pkg::B_DATA: state_nxt = direct ? vlns_pkg::B_EMIT : vlns_pkg::B_DIV;
      vlns_pkg::B_DIV:  if (step_r == '0) state_nxt = vlns_pkg::B_SQRT;
      vlns_pkg::B_SQRT: if (step_r == '0) state_nxt = vlns_pkg::B_EMIT;
      vlns_pkg::B_EMIT: begin
        if (slot_free) state_nxt = is_last ? vlns_pkg::B_IDLE : vlns_pkg::B_READ;
      end
      default: state_nxt = vlns_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    ram_re    = (state_r == vlns_pkg::B_READ);
    ram_raddr = {head.bank, idx_r[IDX_W-1:0]};
    emit      = (state_r == vlns_pkg::B_EMIT) && slot_free;
    pop       = emit && is_last;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vlns_pkg::B_DATA: begin
        neg_r  <= x[vlns_pkg::ELEM_W-1];
        res_r  <= head.mode ? '0 : x;
        rem_r  <= vlns_pkg::SUM_W'(mag2 >> 1);
        num_r  <= {mag2[0], 32'b0};
        step_r <= direct ? '0 : vlns_pkg::STEP_W'(vlns_pkg::QUOT_W - 1);
      end
      vlns_pkg::B_DIV: begin
        num_r <= num_r << 1;
        if (!div_diff[vlns_pkg::SUM_W]) begin
          rem_r  <= div_diff[vlns_pkg::SUM_W-1:0];
          quot_r <= {quot_r[vlns_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= div_sh[vlns_pkg::SUM_W-1:0];
          quot_r <= {quot_r[vlns_pkg::QUOT_W-2:0], 1'b0};
        end
        if (step_r == '0) begin
          rad_r  <= {1'b0, (div_diff[vlns_pkg::SUM_W] ? {quot_r[vlns_pkg::QUOT_W-2:0], 1'b0}
                                                      : {quot_r[vlns_pkg::QUOT_W-2:0], 1'b1})};
          srem_r <= '0;
          root_r <= '0;
          step_r <= vlns_pkg::STEP_W'(vlns_pkg::ROOT_W - 1);
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
      vlns_pkg::B_SQRT: begin
        rad_r <= rad_r << 2;
        if (sq_sh >= sq_trial) begin
          srem_r <= sq_sh - sq_trial;
          root_r <= {root_r[vlns_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= sq_sh;
          root_r <= {root_r[vlns_pkg::ROOT_W-2:0], 1'b0};
        end
        // the last step wraps to all ones, marking a scaled result
        step_r <= step_r - 1'b1;
      end
      default: ;
    endcase
    if (state_r == vlns_pkg::B_EMIT && state_nxt == vlns_pkg::B_EMIT && step_r == '1) begin
      res_r <= res_norm;
    end
    if (emit) begin
      out_value     <= (step_r == '1) ? res_norm : res_r;
      out_position  <= idx_r[vlns_pkg::POS_W-1:0];
      out_vector_id <= head.vid;
      out_last      <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vlns_pkg::B_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/vector_l2_normalize_store_top.sv
// channel  direction  ports                                          handshake
// config   in         cfg_we cfg_index cfg_data                      write on cfg_we
// element  in         in_element                                     in_valid / in_stall
// result   out        out_value out_position out_vector_id out_last  out_valid / out_stall
//
// loading takes one element per cycle while in_stall is low; a vector is handed to the
// back end once complete; output copy mode: each element passes the read, data and emit
// states; normalize mode adds the bit-serial divider (33 steps) and root unit (17 steps)
// for a nonzero element; two vector banks: the next vector loads while the previous is emitted
// in_stall rises while both banks hold unsent vectors; rst_n is synchronous, active low
module vector_l2_normalize_store_top #(
  parameter int MAX_DIM  = vlns_pkg::MAX_DIM_DEF,
  parameter int CAPACITY = vlns_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [vlns_pkg::DIM_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vlns_pkg::ELEM_W-1:0] in_element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vlns_pkg::ELEM_W-1:0] out_value,
  output logic [vlns_pkg::POS_W-1:0]  out_position,
  output logic [vlns_pkg::VID_W-1:0]  out_vector_id,
  output logic                        out_last
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic                        q_full, q_empty, push, pop;
  vlns_pkg::desc_t             push_desc, head;
  logic                        ram_we, ram_re;
  logic [IDX_W:0]              ram_waddr, ram_raddr;
  logic [vlns_pkg::ELEM_W-1:0] ram_wdata, ram_rdata;

  vlns_front #(.MAX_DIM(MAX_DIM), .CAPACITY(CAPACITY)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_element, .in_stall,
    .q_full, .push, .push_desc,
    .ram_we, .ram_waddr, .ram_wdata
  );

  vlns_queue u_queue (
    .clk, .rst_n, .push, .push_desc, .pop, .head,
    .full(q_full), .empty(q_empty)
  );

  vlns_ram #(.WIDTH(vlns_pkg::ELEM_W), .DEPTH(2 << IDX_W)) u_ram (
    .clk, .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_en(ram_re), .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  vlns_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk, .rst_n, .head, .empty(q_empty), .pop,
    .ram_re, .ram_raddr, .ram_rdata,
    .out_valid, .out_stall, .out_value, .out_position, .out_vector_id, .out_last
  );

endmodule
